FILE: rtl/core/gtps_pkg.sv
package gtps_pkg;

    // Ring geometry
    localparam int SLAB_COUNT      = 16;
    localparam int FRAMES_PER_SLAB = 64;
    localparam int CHANNELS        = 2;

    localparam int SLOT_W   = $clog2(SLAB_COUNT);
    localparam int PTR_W    = SLOT_W + 1;
    localparam int FRM_W    = $clog2(FRAMES_PER_SLAB);
    localparam int ADDR_W   = SLOT_W + FRM_W;
    localparam int STORE_D  = SLAB_COUNT * FRAMES_PER_SLAB;
    localparam int LEN_W    = 7;
    localparam int FILL_W   = 8;
    localparam int CNT_W    = 11;
    localparam int BYTE_W   = 14;
    localparam int RES_W    = 7;
    localparam int FRAME_SH = $clog2(4 * CHANNELS);

    localparam logic [63:0] SAMPLE_MASK =
        (CHANNELS >= 2) ? {64{1'b1}} : {32'h0, {32{1'b1}}};

    // Action codes
    localparam logic [2:0] ACT_PUBLISH = 3'd0;
    localparam logic [2:0] ACT_CONSUME = 3'd1;
    localparam logic [2:0] ACT_DISCARD = 3'd2;
    localparam logic [2:0] ACT_FLUSH   = 3'd3;
    localparam logic [2:0] ACT_QUERY   = 3'd4;
    localparam logic [2:0] ACT_PEAK    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_STALE    = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_UNDERRUN = 3'd4;

    typedef struct packed {
        logic [2:0]       action;
        logic [63:0]      generation;
        logic [63:0]      sample_frame;
        logic             frame_last;
        logic [CNT_W-1:0] frame_count;
    } t_in;

    typedef struct packed {
        logic [63:0]       out_frame;
        logic [2:0]        status;
        logic              silent;
        logic [CNT_W-1:0]  count_out;
        logic [4:0]        stale_slab_count;
        logic [63:0]       current_generation;
        logic [4:0]        queued_slab_count;
        logic [BYTE_W-1:0] unread_byte_count;
        logic [BYTE_W-1:0] peak_byte_count;
        logic              result_last;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic drain;
        logic rd;
        logic load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic no_result;
        logic need_drain;
        logic drain_done;
        logic last_idx;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/gtps_ram.sv
module gtps_ram #(
    parameter int W = 64,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gtps_ctrl.sv
module gtps_ctrl
    import gtps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN,
        S_RD,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    // Sequencing
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.no_result) begin
                    n_state = S_IDLE;
                end else if (i_sts.need_drain) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DRAIN: begin
                if (i_sts.drain_done) begin
                    n_state = S_RD;
                end else begin
                    o_cmd.drain = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.last_idx ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    // No transfer in while reset is held
    assign o_in_stall = r_stall || !i_rst_n;

    // Stall is low exactly in idle
    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall == (r_state != S_IDLE))
        else $error("stall out of step with state");

    // A transfer in is always followed by execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    // A load only happens with a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("load into busy output register");

endmodule

FILE: rtl/core/gtps_dp.sv
module gtps_dp
    import gtps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    // Held item
    t_in r_item;

    // Ring state
    logic [PTR_W-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [LEN_W-1:0]  r_off, n_off;
    logic [63:0]       r_tag, n_tag;
    logic [BYTE_W-1:0] r_unread, n_unread, r_peak, n_peak;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_blocked, n_blocked;
    logic [LEN_W-1:0]  r_len [SLAB_COUNT];

    // Per-item sequencing
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [PTR_W-1:0]  r_sp, n_sp;
    logic [LEN_W-1:0]  r_soff, n_soff;
    logic [RES_W-1:0]  r_idx, n_idx, r_nres, n_nres, r_got, n_got;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [2:0]        r_status, n_status;
    logic              r_pad, n_pad;

    // Output register
    logic r_ovalid, n_ovalid;
    t_out r_out, n_out;

    // Store port
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [63:0]       ram_wdata, ram_rdata;

    logic              len_we;
    logic [SLOT_W-1:0] len_slot;
    logic [LEN_W-1:0]  len_val;

    logic [PTR_W-1:0]  queued;
    logic              full, current;
    logic [CNT_W-1:0]  avail, got_c;
    logic [FILL_W-1:0] fill_n;
    logic [LEN_W-1:0]  head_left, slen, soff_n;
    logic [BYTE_W-1:0] peak_now;

    assign queued   = r_wp - r_rp;
    assign full     = (queued >= PTR_W'(SLAB_COUNT));
    assign current  = (r_item.generation != 64'd0) && (r_item.generation == r_tag);
    assign avail    = CNT_W'(r_unread >> FRAME_SH);
    assign got_c    = (r_item.frame_count < avail) ? r_item.frame_count : avail;
    assign fill_n   = (r_fill <= FILL_W'(FRAMES_PER_SLAB)) ? r_fill + 1'b1 : r_fill;
    assign head_left = r_len[r_rp[SLOT_W-1:0]] - r_off;
    assign slen     = r_len[r_sp[SLOT_W-1:0]];
    assign soff_n   = r_soff + 1'b1;
    assign peak_now = (r_peak > r_unread) ? r_peak : r_unread;

    // Next-state logic
    always_comb begin
        n_wp = r_wp;  n_rp = r_rp;  n_off = r_off;  n_tag = r_tag;
        n_unread = r_unread;  n_peak = r_peak;
        n_fill = r_fill;  n_blocked = r_blocked;
        n_remain = r_remain;  n_sp = r_sp;  n_soff = r_soff;
        n_idx = r_idx;  n_nres = r_nres;  n_got = r_got;  n_cnt = r_cnt;
        n_status = r_status;  n_pad = r_pad;
        n_ovalid = r_ovalid;  n_out = r_out;
        ram_we = 1'b0;  ram_re = 1'b0;
        ram_waddr = {r_wp[SLOT_W-1:0], r_fill[FRM_W-1:0]};
        ram_wdata = r_item.sample_frame & SAMPLE_MASK;
        ram_raddr = {r_sp[SLOT_W-1:0], r_soff[FRM_W-1:0]};
        len_we = 1'b0;
        len_slot = r_wp[SLOT_W-1:0];
        len_val = LEN_W'(fill_n);

        // Result set-up and single-step actions
        if (i_cmd.exec) begin
            n_idx = '0;  n_nres = RES_W'(1);  n_got = '0;  n_cnt = '0;
            n_pad = 1'b0;  n_remain = '0;  n_status = ST_INVALID;
            n_sp = r_rp;  n_soff = r_off;
            case (r_item.action)
                ACT_PUBLISH: begin
                    if (full) begin
                        n_blocked = 1'b1;
                    end else if (r_fill < FILL_W'(FRAMES_PER_SLAB)) begin
                        ram_we = 1'b1;
                    end
                    if (!r_item.frame_last) begin
                        n_fill = fill_n;
                        n_nres = '0;
                    end else begin
                        n_fill = '0;
                        n_blocked = 1'b0;
                        if (r_item.generation == 64'd0 ||
                            fill_n > FILL_W'(FRAMES_PER_SLAB)) begin
                            n_status = ST_INVALID;
                        end else if (r_item.generation != r_tag) begin
                            n_status = ST_STALE;
                        end else if (r_blocked || full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            len_we = 1'b1;
                            n_unread = r_unread + (BYTE_W'(fill_n) << FRAME_SH);
                            if (n_unread > r_peak) begin
                                n_peak = n_unread;
                            end
                            n_wp = r_wp + 1'b1;
                        end
                    end
                end
                ACT_CONSUME: begin
                    if (r_item.frame_count == '0 ||
                        r_item.frame_count > CNT_W'(FRAMES_PER_SLAB)) begin
                        n_status = ST_INVALID;
                    end else if (!current) begin
                        n_status = ST_STALE;
                        n_nres = RES_W'(r_item.frame_count);
                        n_pad = 1'b1;
                    end else begin
                        n_status = (got_c < r_item.frame_count) ? ST_UNDERRUN : ST_OK;
                        n_nres = RES_W'(r_item.frame_count);
                        n_got = RES_W'(got_c);
                        n_cnt = got_c;
                        n_pad = 1'b1;
                        n_remain = got_c;
                    end
                end
                ACT_DISCARD: begin
                    if (!current) begin
                        n_status = ST_STALE;
                    end else if (r_item.frame_count == '0) begin
                        n_status = ST_INVALID;
                    end else begin
                        n_status = ST_OK;
                        n_cnt = got_c;
                        n_remain = got_c;
                    end
                end
                ACT_FLUSH: begin
                    if (r_item.generation != 64'd0 && r_item.generation > r_tag) begin
                        n_status = ST_OK;
                        n_rp = r_wp;
                        n_off = '0;
                        n_unread = '0;
                        n_peak = '0;
                        n_tag = r_item.generation;
                    end
                end
                ACT_QUERY: begin
                    if (!current) begin
                        n_status = ST_STALE;
                    end else begin
                        n_status = ST_OK;
                        n_cnt = avail;
                    end
                end
                ACT_PEAK: begin
                    if (!current) begin
                        n_status = ST_STALE;
                    end else begin
                        n_status = ST_OK;
                        n_peak = r_unread;
                    end
                end
                default: n_status = ST_INVALID;
            endcase
        end

        // Retire frames from the head slab, one slab per cycle
        if (i_cmd.drain) begin
            if (r_remain >= CNT_W'(head_left)) begin
                n_rp = r_rp + 1'b1;
                n_off = '0;
                n_remain = r_remain - CNT_W'(head_left);
                n_unread = r_unread - (BYTE_W'(head_left) << FRAME_SH);
            end else begin
                n_off = r_off + LEN_W'(r_remain);
                n_remain = '0;
                n_unread = r_unread - (BYTE_W'(r_remain) << FRAME_SH);
            end
        end

        // Fetch the next frame along the saved cursor
        if (i_cmd.rd && (r_idx < r_got)) begin
            ram_re = 1'b1;
            if (soff_n == slen) begin
                n_sp = r_sp + 1'b1;
                n_soff = '0;
            end else begin
                n_soff = soff_n;
            end
        end

        // Output register
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        if (i_cmd.load) begin
            n_ovalid = 1'b1;
            n_out.out_frame = (r_idx < r_got) ? ram_rdata : 64'd0;
            n_out.status = r_status;
            n_out.silent = r_pad && (r_idx >= r_got);
            n_out.count_out = r_cnt;
            n_out.stale_slab_count = '0;
            n_out.current_generation = r_tag;
            n_out.queued_slab_count = 5'(queued);
            n_out.unread_byte_count = r_unread;
            n_out.peak_byte_count = peak_now;
            n_out.result_last = (r_idx == r_nres - 1'b1);
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;  r_rp <= '0;  r_off <= '0;  r_tag <= 64'd1;
            r_unread <= '0;  r_peak <= '0;  r_fill <= '0;  r_blocked <= 1'b0;
            r_remain <= '0;  r_sp <= '0;  r_soff <= '0;
            r_idx <= '0;  r_nres <= '0;  r_got <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_wp <= n_wp;  r_rp <= n_rp;  r_off <= n_off;  r_tag <= n_tag;
            r_unread <= n_unread;  r_peak <= n_peak;
            r_fill <= n_fill;  r_blocked <= n_blocked;
            r_remain <= n_remain;  r_sp <= n_sp;  r_soff <= n_soff;
            r_idx <= n_idx;  r_nres <= n_nres;  r_got <= n_got;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
        end
        if (len_we) begin
            r_len[len_slot] <= len_val;
        end
        r_cnt <= n_cnt;
        r_status <= n_status;
        r_pad <= n_pad;
        r_out <= n_out;
    end

    gtps_ram #(
        .W(64),
        .D(STORE_D)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Drain is needed when a current consume or discard retires any frame
    assign o_sts.no_result  = (r_item.action == ACT_PUBLISH) && !r_item.frame_last;
    assign o_sts.need_drain = current && (got_c != '0) &&
                              (((r_item.action == ACT_CONSUME) &&
                                (r_item.frame_count <= CNT_W'(FRAMES_PER_SLAB))) ||
                               (r_item.action == ACT_DISCARD));
    assign o_sts.drain_done = (r_remain == '0);
    assign o_sts.last_idx   = (r_idx == r_nres - 1'b1);
    assign o_sts.out_free   = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // Unread bytes are always whole frames
    a_whole_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unread[FRAME_SH-1:0] == '0)
        else $error("unread byte count not frame aligned");

    // Never more slabs queued than the ring holds
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queued <= PTR_W'(SLAB_COUNT))
        else $error("ring over-committed");

    // Empty ring holds no unread bytes
    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (queued == '0) |-> (r_unread == '0) && (r_off == '0))
        else $error("bytes left in empty ring");

endmodule

FILE: rtl/core/generation_tagged_pcm_slab_ring.sv
// Generation-tagged PCM slab ring. Items are taken one at a time: an item is
// accepted, executed in the following cycle, and its results then leave through
// a single output register. A publish frame other than the last gives no result;
// the last one, which commits or refuses the slab, gives one. A consume or
// discard that retires frames first drains them from one slab at a time, and
// each result frame then passes the registered read of the frame store and the
// output register. Output stall only holds the block at a result load. Input
// stall is held high during reset.
// No clearing pass is needed after reset; frame store and slab lengths are
// only read for committed slabs.
module generation_tagged_pcm_slab_ring
    import gtps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_cmd cmd;
    t_sts sts;

    gtps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    gtps_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule
